// File: design/nlb_pkg.sv
`default_nettype none
package nlb_pkg;
    localparam int NodeSlotsDef  = 16;
    localparam int OrderDepthDef = 32;
    localparam int ConnBitsDef   = 32;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_SETW   = 3'd2;
    localparam logic [2:0] OP_INC    = 3'd3;
    localparam logic [2:0] OP_DEC    = 3'd4;
    localparam logic [2:0] OP_SELECT = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] SG_RR     = 2'd0;
    localparam logic [1:0] SG_LEAST  = 2'd1;
    localparam logic [1:0] SG_WEIGHT = 2'd2;
    localparam logic [1:0] SG_RAND   = 2'd3;

    // divider request / response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

// File: design/nlb_divider.sv
`default_nettype none
// Restoring remainder unit: one quotient bit a cycle.
module nlb_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nlb_pkg::t_div_req i_req,
    output nlb_pkg::t_div_rsp      o_rsp
);
    import nlb_pkg::*;

    logic [31:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [32:0] w_shift, w_diff;

    always_comb begin
        w_shift = {r_rem[31:0], r_num[31]};
        w_diff  = w_shift - {1'b0, r_den};
        n_num = r_num; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_num = i_req.dividend; n_rem = '0; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[30:0], 1'b0};
            n_rem = w_diff[32] ? w_shift : w_diff;
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) r_den <= i_req.divisor;
        r_num <= n_num; r_rem <= n_rem; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[31:0];
endmodule
`default_nettype wire

// File: design/node_load_balancer_top.sv
`default_nettype none
// Node load balancer.
// Input channel: operation and fields are taken at a clock edge with
// start high and busy low. Each item yields one result, shown for one
// cycle with o_done high; the receiver cannot stall it.
// Configuration: i_cfg_valid / o_cfg_ready write the 2-bit strategy;
// writing round robin also clears the round-robin counter.
// Add, set weight, increment, decrement and clear go from S_EXEC to S_OUT.
// Remove sweeps the order list, reading (S_RMRD) and then conditionally
// rewriting (S_RMWR) each entry.
// Least-connections and weighted select scan the slot table once (S_SCAN);
// weighted, random and round-robin selection also use the shared
// remainder unit; weighted and random then walk the table (S_WALK), so
// weighted makes up to two table passes, and round robin reads the order
// list. The walk and the divider set the rate; one item is in flight at a time.
// Reset empties the table and order list and sets strategy round robin.
// Order list lives in a one-port memory whose read data is registered in r_ord_q.
module node_load_balancer_top #(
    parameter int NODE_SLOTS  = nlb_pkg::NodeSlotsDef,
    parameter int ORDER_DEPTH = nlb_pkg::OrderDepthDef,
    parameter int CONN_BITS   = nlb_pkg::ConnBitsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_operation,
    input  wire logic [3:0]  i_node_slot,
    input  wire logic [15:0] i_node_weight,
    input  wire logic [31:0] i_initial_conns,
    input  wire logic [31:0] i_random_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,
    output logic             o_done,
    output logic             o_selected,
    output logic [3:0]       o_chosen_slot,
    output logic [15:0]      o_chosen_weight,
    output logic [31:0]      o_chosen_conns,
    output logic [1:0]       o_status,
    output logic [4:0]       o_live_nodes
);
    import nlb_pkg::*;

    localparam int SW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int OW = $clog2(ORDER_DEPTH);
    localparam int LW = $clog2(ORDER_DEPTH + 1);
    localparam int VW = $clog2(NODE_SLOTS + 1);
    localparam logic [CONN_BITS-1:0] CMAX = '1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EXEC  = 10'b0000000010,
        S_RMRD  = 10'b0000000100,
        S_RMWR  = 10'b0000001000,
        S_SCAN  = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_WALK  = 10'b0001000000,
        S_RRRD  = 10'b0010000000,
        S_RRGET = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [1:0] r_strategy;
    logic [NODE_SLOTS-1:0] r_valid;
    logic [15:0] r_weight [NODE_SLOTS];
    logic [CONN_BITS-1:0] r_conns [NODE_SLOTS];
    logic [SW-1:0] r_order [ORDER_DEPTH];
    logic [SW-1:0] r_ord_q;
    logic [LW-1:0] r_olen, r_ri, r_wi;
    logic [31:0] r_rr;
    logic [VW-1:0] r_vcnt;

    logic [2:0]  r_op;
    logic [3:0]  r_slot;
    logic [15:0] r_w;
    logic [CONN_BITS-1:0] r_ic;
    logic [31:0] r_rnd;

    logic [SW:0]  r_si;        // walk index, one extra bit for end
    logic [31:0]  r_acc;       // total weight / pick
    logic [CONN_BITS-1:0] r_best;
    logic         r_found;
    logic [SW-1:0] r_pick;
    logic         r_res_sel;
    logic [1:0]   r_res_st;

    t_div_req r_dreq;
    t_div_rsp w_drsp;

    nlb_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_dreq), .o_rsp(w_drsp));

    logic w_inrange, w_present;
    logic [SW-1:0] w_s, w_wk;
    logic w_wk_v;
    assign w_inrange = ({28'd0, r_slot} < 32'(NODE_SLOTS));
    assign w_s       = SW'(r_slot);
    assign w_present = w_inrange && r_valid[w_s];
    assign w_wk      = r_si[SW-1:0];
    assign w_wk_v    = r_valid[w_wk];

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_strategy <= SG_RR; r_valid <= '0;
            r_olen <= '0; r_rr <= '0; r_vcnt <= '0;
            r_dreq.start <= 1'b0;
        end else begin
            r_dreq.start <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_strategy <= i_cfg_data;
                if (i_cfg_data == SG_RR) r_rr <= '0;
            end
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_op <= i_operation; r_slot <= i_node_slot; r_w <= i_node_weight;
                    r_ic <= CONN_BITS'(i_initial_conns); r_rnd <= i_random_value;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_res_sel <= 1'b0; r_res_st <= ST_OK; r_state <= S_OUT;
                    r_si <= '0; r_acc <= '0; r_found <= 1'b0; r_ri <= '0; r_wi <= '0;
                    case (r_op)
                        OP_ADD: begin
                            if (!w_inrange) r_res_st <= ST_ABSENT;
                            else if (r_olen >= LW'(ORDER_DEPTH)) r_res_st <= ST_FULL;
                            else begin
                                if (!r_valid[w_s]) r_vcnt <= r_vcnt + 1'b1;
                                r_valid[w_s] <= 1'b1; r_weight[w_s] <= r_w;
                                r_conns[w_s] <= r_ic;
                                r_order[r_olen[OW-1:0]] <= w_s;
                                r_olen <= r_olen + 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (w_present) begin
                                r_valid[w_s] <= 1'b0; r_vcnt <= r_vcnt - 1'b1;
                            end else r_res_st <= ST_ABSENT;
                            if (w_inrange) r_state <= S_RMRD;
                        end
                        OP_SETW: if (w_present) r_weight[w_s] <= r_w;
                                 else r_res_st <= ST_ABSENT;
                        OP_INC: if (!w_present) r_res_st <= ST_ABSENT;
                                else if (r_conns[w_s] != CMAX)
                                    r_conns[w_s] <= r_conns[w_s] + 1'b1;
                        OP_DEC: if (!w_present) r_res_st <= ST_ABSENT;
                                else if (r_conns[w_s] != '0)
                                    r_conns[w_s] <= r_conns[w_s] - 1'b1;
                        OP_SELECT: begin
                            if (r_vcnt == '0) r_res_st <= ST_EMPTY;
                            else if (r_strategy == SG_RR) begin
                                if (r_olen == '0) r_res_st <= ST_EMPTY;
                                else begin
                                    r_dreq.start <= 1'b1; r_dreq.dividend <= r_rr;
                                    r_dreq.divisor <= 32'(r_olen);
                                    r_rr <= r_rr + 32'd1; r_state <= S_DIV;
                                end
                            end else if (r_strategy == SG_RAND) begin
                                r_dreq.start <= 1'b1; r_dreq.dividend <= r_rnd;
                                r_dreq.divisor <= 32'(r_vcnt); r_state <= S_DIV;
                            end else r_state <= S_SCAN;
                        end
                        OP_CLEAR: begin
                            r_valid <= '0; r_vcnt <= '0; r_olen <= '0; r_rr <= '0;
                        end
                        default: ;
                    endcase
                end
                // compaction: read, then conditionally write
                S_RMRD: if (r_ri == r_olen) begin
                    r_olen <= r_wi; r_state <= S_OUT;
                end else begin
                    r_ord_q <= r_order[r_ri[OW-1:0]]; r_ri <= r_ri + 1'b1; r_state <= S_RMWR;
                end
                S_RMWR: begin
                    if (r_ord_q != w_s) begin
                        r_order[r_wi[OW-1:0]] <= r_ord_q; r_wi <= r_wi + 1'b1;
                    end
                    r_state <= S_RMRD;
                end
                // least: min search; weighted: total sum
                S_SCAN: if (r_si == (SW+1)'(NODE_SLOTS)) begin
                    if (r_strategy == SG_LEAST) begin
                        r_res_sel <= 1'b1; r_state <= S_OUT;
                    end else if (r_acc == '0) begin
                        r_res_sel <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_dreq.start <= 1'b1; r_dreq.dividend <= r_rnd;
                        r_dreq.divisor <= r_acc; r_state <= S_DIV;
                    end
                end else begin
                    r_si <= r_si + 1'b1;
                    if (w_wk_v) begin
                        if (r_strategy == SG_LEAST) begin
                            if (!r_found || r_conns[w_wk] < r_best) begin
                                r_best <= r_conns[w_wk]; r_pick <= w_wk;
                            end
                        end else begin
                            r_acc <= r_acc + 32'(r_weight[w_wk]);
                            if (!r_found) r_pick <= w_wk;
                        end
                        r_found <= 1'b1;
                    end
                end
                S_DIV: if (w_drsp.done) begin
                    r_si <= '0;
                    if (r_strategy == SG_RR) begin
                        r_ri <= LW'(w_drsp.rem); r_state <= S_RRRD;
                    end else if (r_strategy == SG_WEIGHT) begin
                        r_acc <= w_drsp.rem; r_state <= S_WALK;   // pick-1
                    end else begin
                        r_acc <= w_drsp.rem; r_state <= S_WALK;   // nth
                    end
                end
                // walk: weighted pick reaches running sum, or nth valid
                S_WALK: if (r_si == (SW+1)'(NODE_SLOTS)) begin
                    r_res_st <= ST_EMPTY; r_state <= S_OUT;
                end else begin
                    r_si <= r_si + 1'b1;
                    if (w_wk_v) begin
                        if (r_strategy == SG_WEIGHT) begin
                            if (r_acc < 32'(r_weight[w_wk])) begin
                                r_pick <= w_wk; r_res_sel <= 1'b1; r_state <= S_OUT;
                            end else r_acc <= r_acc - 32'(r_weight[w_wk]);
                        end else begin
                            if (r_acc == '0) begin
                                r_pick <= w_wk; r_res_sel <= 1'b1; r_state <= S_OUT;
                            end else r_acc <= r_acc - 32'd1;
                        end
                    end
                end
                S_RRRD: begin
                    r_ord_q <= r_order[r_ri[OW-1:0]]; r_state <= S_RRGET;
                end
                S_RRGET: begin
                    r_pick <= r_ord_q; r_state <= S_OUT;
                    if (r_valid[r_ord_q]) r_res_sel <= 1'b1;
                    else r_res_st <= ST_EMPTY;
                end
                S_OUT: begin
                    o_done <= 1'b1; r_state <= S_IDLE;
                    o_selected <= r_res_sel; o_status <= r_res_st;
                    o_live_nodes <= 5'(r_vcnt);
                    o_chosen_slot <= r_res_sel ? 4'(r_pick) : 4'd0;
                    o_chosen_weight <= r_res_sel ? r_weight[r_pick] : 16'd0;
                    o_chosen_conns <= r_res_sel ? 32'(r_conns[r_pick]) : 32'd0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/nlb_checker.sv
`default_nettype none
module nlb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_cfg_ready,
    input wire logic       o_done,
    input wire logic       o_selected,
    input wire logic [1:0] o_status,
    input wire logic [4:0] o_live_nodes
);
    // an accepted item makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("not busy after transfer");
    // a result ends the busy period
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("busy with result");
    // selected only with ok status
    a_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_selected |-> o_status == 2'd0) else $error("bad select status");
    // no configuration while working
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready) else $error("cfg while busy");
    a_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_live_nodes <= 5'd16) else $error("live count range");
endmodule

bind node_load_balancer_top nlb_checker u_chk (.*);
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
    import nlb_pkg::*;

    localparam int SLOTS      = 16;
    localparam int DEPTH      = 32;
    localparam int N_RANDOM   = 600;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [31:0] CONN_MAX = 32'hFFFF_FFFF;

    // one balancer answer
    typedef struct packed {
        logic        selected;
        logic [3:0]  slot;
        logic [15:0] weight;
        logic [31:0] conns;
        logic [1:0]  status;
        logic [4:0]  live;
    } t_answer;

    // one directed row; check_now means the answer column is typed in
    typedef struct {
        logic [2:0]  op;
        logic [3:0]  slot;
        logic [15:0] weight;
        logic [31:0] conns;
        logic [31:0] rnd;
        bit          check_now;
        t_answer     answer;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_operation = '0;
    logic [3:0]  i_node_slot = '0;
    logic [15:0] i_node_weight = '0;
    logic [31:0] i_initial_conns = '0;
    logic [31:0] i_random_value = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data = '0;
    logic        o_done;
    logic        o_selected;
    logic [3:0]  o_chosen_slot;
    logic [15:0] o_chosen_weight;
    logic [31:0] o_chosen_conns;
    logic [1:0]  o_status;
    logic [4:0]  o_live_nodes;

    node_load_balancer_top DUT (.*);

    always #4 i_clk = ~i_clk;

    // mirror of the node table
    logic        mv_valid [SLOTS];
    logic [15:0] mv_weight [SLOTS];
    logic [31:0] mv_conns [SLOTS];
    logic [3:0]  mv_order [DEPTH];
    int unsigned mv_len;
    logic [31:0] mv_rr;
    int unsigned mv_live;
    logic [1:0]  mv_strategy;

    t_answer pending_answers[$];
    int      error_count = 0;
    int      idle_cycles = 0;

    t_row rows[$];

    function automatic void table_reset();
        for (int s = 0; s < SLOTS; s++) begin
            mv_valid[s] = 1'b0;
            mv_weight[s] = '0;
            mv_conns[s] = '0;
        end
        mv_len = 0;
        mv_rr = '0;
        mv_live = 0;
        mv_strategy = SG_RR;
    endfunction

    // append one directed row to the table
    function automatic void queue_row(logic [2:0] op, logic [3:0] slot, logic [15:0] w,
                                      logic [31:0] c, logic [31:0] rnd, bit chk,
                                      t_answer a);
        t_row r;
        r.op = op;
        r.slot = slot;
        r.weight = w;
        r.conns = c;
        r.rnd = rnd;
        r.check_now = chk;
        r.answer = a;
        rows.insert(rows.size(), r);
    endfunction

    // choose a node under the current strategy; -1 when none
    function automatic int choose_node(logic [31:0] rnd);
        logic [63:0] total, cum, pick;
        int n;
        int found;
        logic [31:0] best;
        found = -1;
        best = '0;
        total = '0;
        cum = '0;
        case (mv_strategy)
            SG_RR: begin
                if (mv_len == 0) return -1;
                n = int'(mv_rr % mv_len);
                mv_rr = mv_rr + 1;
                return mv_valid[mv_order[n]] ? int'(mv_order[n]) : -1;
            end
            SG_LEAST: begin
                for (int s = 0; s < SLOTS; s++)
                    if (mv_valid[s] && (found < 0 || mv_conns[s] < best)) begin
                        found = s;
                        best = mv_conns[s];
                    end
                return found;
            end
            SG_WEIGHT: begin
                for (int s = 0; s < SLOTS; s++)
                    if (mv_valid[s]) total += mv_weight[s];
                if (total != 0) begin
                    pick = {32'd0, rnd} % total + 1;
                    for (int s = 0; s < SLOTS; s++)
                        if (mv_valid[s]) begin
                            cum += mv_weight[s];
                            if (pick <= cum) return s;
                        end
                end
                for (int s = 0; s < SLOTS; s++)
                    if (mv_valid[s]) return s;
                return -1;
            end
            default: begin
                if (mv_live == 0) return -1;
                n = int'(rnd % mv_live);
                for (int s = 0; s < SLOTS; s++)
                    if (mv_valid[s]) begin
                        if (n == 0) return s;
                        n--;
                    end
                return -1;
            end
        endcase
    endfunction

    // apply one operation to the mirror and return its answer
    function automatic t_answer apply_operation(logic [2:0] op, logic [3:0] slot,
                                                logic [15:0] w, logic [31:0] c,
                                                logic [31:0] rnd);
        t_answer a;
        int j;
        int pick;
        a = '0;
        a.status = ST_OK;
        case (op)
            OP_ADD: begin
                if (mv_len >= DEPTH) a.status = ST_FULL;
                else begin
                    if (!mv_valid[slot]) mv_live++;
                    mv_valid[slot] = 1'b1;
                    mv_weight[slot] = w;
                    mv_conns[slot] = c;
                    mv_order[mv_len] = slot;
                    mv_len++;
                end
            end
            OP_REMOVE: begin
                if (mv_valid[slot]) begin
                    mv_valid[slot] = 1'b0;
                    mv_live--;
                end else a.status = ST_ABSENT;
                j = 0;
                for (int i = 0; i < mv_len; i++)
                    if (mv_order[i] != slot) begin
                        mv_order[j] = mv_order[i];
                        j++;
                    end
                mv_len = j;
            end
            OP_SETW: begin
                if (mv_valid[slot]) mv_weight[slot] = w;
                else a.status = ST_ABSENT;
            end
            OP_INC: begin
                if (!mv_valid[slot]) a.status = ST_ABSENT;
                else if (mv_conns[slot] != CONN_MAX) mv_conns[slot]++;
            end
            OP_DEC: begin
                if (!mv_valid[slot]) a.status = ST_ABSENT;
                else if (mv_conns[slot] != 0) mv_conns[slot]--;
            end
            OP_SELECT: begin
                pick = (mv_live == 0) ? -1 : choose_node(rnd);
                if (pick < 0) a.status = ST_EMPTY;
                else begin
                    a.selected = 1'b1;
                    a.slot = pick[3:0];
                    a.weight = mv_weight[pick];
                    a.conns = mv_conns[pick];
                end
            end
            OP_CLEAR: begin
                for (int s = 0; s < SLOTS; s++) mv_valid[s] = 1'b0;
                mv_live = 0;
                mv_len = 0;
                mv_rr = '0;
            end
            default: ;
        endcase
        a.live = mv_live[4:0];
        return a;
    endfunction

    // result checker and idle watchdog
    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n && o_done) begin
            got = {o_selected, o_chosen_slot, o_chosen_weight, o_chosen_conns,
                   o_status, o_live_nodes};
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (got.selected !== want.selected)
                    $display("%0t: selected exp %h got %h", $time, want.selected, got.selected);
                if (got.slot !== want.slot)
                    $display("%0t: slot exp %h got %h", $time, want.slot, got.slot);
                if (got.weight !== want.weight)
                    $display("%0t: weight exp %h got %h", $time, want.weight, got.weight);
                if (got.conns !== want.conns)
                    $display("%0t: conns exp %h got %h", $time, want.conns, got.conns);
                if (got.status !== want.status)
                    $display("%0t: status exp %h got %h", $time, want.status, got.status);
                if (got.live !== want.live)
                    $display("%0t: live exp %h got %h", $time, want.live, got.live);
                if (got !== want) error_count++;
            end
        end
        if (o_done || (start && !busy) || (i_cfg_valid && o_cfg_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // present one item and wait for its transfer; start stays high unless a gap follows
    task automatic issue(logic [2:0] op, logic [3:0] slot, logic [15:0] w,
                         logic [31:0] c, logic [31:0] rnd, bit gaps);
        int n;
        i_operation <= op;
        i_node_slot <= slot;
        i_node_weight <= w;
        i_initial_conns <= c;
        i_random_value <= rnd;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_answers.insert(pending_answers.size(), apply_operation(op, slot, w, c, rnd));
        @(negedge i_clk);
        if (gaps) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if (n != 0) begin
                start <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
        end
    endtask

    task automatic write_strategy(logic [1:0] sg);
        start <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        i_cfg_data <= sg;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mv_strategy = sg;
        if (sg == SG_RR) mv_rr = '0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly well-formed table traffic with select-heavy mix
    task automatic random_item();
        logic [2:0] op;
        int r;
        logic [31:0] c;
        r = $urandom_range(0, 99);
        if (r < 25) op = OP_ADD;
        else if (r < 33) op = OP_REMOVE;
        else if (r < 40) op = OP_SETW;
        else if (r < 50) op = OP_INC;
        else if (r < 60) op = OP_DEC;
        else if (r < 98) op = OP_SELECT;
        else if (r < 99) op = OP_CLEAR;
        else op = 3'd7;
        case ($urandom_range(0, 3))
            0: c = CONN_MAX - $urandom_range(0, 2);
            1: c = $urandom_range(0, 3);
            default: c = $urandom;
        endcase
        issue(op, 4'($urandom_range(0, 15)),
              ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                          : 16'($urandom),
              c, $urandom, 1'b1);
    endtask

    initial begin
        t_answer a;
        table_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table: empty select, extremes, saturation, full list, removal, unknown op, clear
        a = '0; a.status = ST_EMPTY;
        queue_row(OP_SELECT, 4'd0, 16'd0, 32'd0, 32'd0, 1'b1, a);
        a = '0; a.status = ST_ABSENT;
        queue_row(OP_SETW, 4'd15, 16'hFFFF, 32'd0, 32'd0, 1'b1, a);
        queue_row(OP_INC, 4'd3, 16'd0, 32'd0, 32'd0, 1'b1, a);
        queue_row(OP_DEC, 4'd3, 16'd0, 32'd0, 32'd0, 1'b1, a);
        queue_row(OP_REMOVE, 4'd3, 16'd0, 32'd0, 32'd0, 1'b1, a);
        a = '0; a.live = 5'd1;
        queue_row(OP_ADD, 4'd0, 16'hFFFF, CONN_MAX, 32'd0, 1'b1, a);
        queue_row(OP_INC, 4'd0, 16'd0, 32'd0, 32'd0, 1'b0, a);
        queue_row(OP_ADD, 4'd15, 16'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, a);
        queue_row(OP_DEC, 4'd15, 16'd0, 32'd0, 32'd0, 1'b0, a);
        queue_row(OP_ADD, 4'd0, 16'd5, 32'd7, 32'd0, 1'b0, a);
        queue_row(OP_SELECT, 4'd0, 16'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, a);
        queue_row(OP_SELECT, 4'd0, 16'd0, 32'd0, 32'd0, 1'b0, a);
        queue_row(OP_SELECT, 4'd0, 16'd0, 32'd0, 32'd0, 1'b0, a);
        for (int i = 0; i < 30; i++)
            queue_row(OP_ADD, 4'(i % 3 + 5), 16'(i), 32'(i), 32'd0, 1'b0, a);
        a = '0; a.status = ST_FULL; a.live = 5'd5;
        queue_row(OP_ADD, 4'd9, 16'd1, 32'd1, 32'd0, 1'b1, a);
        queue_row(OP_REMOVE, 4'd6, 16'd0, 32'd0, 32'd0, 1'b0, a);
        queue_row(OP_SELECT, 4'd0, 16'd0, 32'd0, 32'd0, 1'b0, a);
        queue_row(3'd7, 4'd0, 16'd0, 32'd0, 32'd0, 1'b0, a);
        a = '0;
        queue_row(OP_CLEAR, 4'd0, 16'd0, 32'd0, 32'd0, 1'b1, a);

        foreach (rows[i]) begin
            a = rows[i].answer;
            issue(rows[i].op, rows[i].slot, rows[i].weight, rows[i].conns,
                  rows[i].rnd, 1'b0);
            if (rows[i].check_now && pending_answers[$] !== a) begin
                $display("%0t: row %0d table exp %h predictor %h", $time, i,
                         a, pending_answers[$]);
                error_count++;
            end
        end

        // random phases through every strategy, round robin written again last
        for (int p = 0; p < 6; p++) begin
            logic [1:0] sg;
            sg = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
            if (p == 5) sg = SG_RR;
            write_strategy(sg);
            for (int i = 0; i < N_RANDOM / 6; i++) random_item();
        end

        start <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (error_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
